### hdl/hsl2r_pkg.sv
package hsl2r_pkg;

    // input ranges
    localparam logic [8:0] FULL_DEG = 9'd360;
    localparam logic [6:0] FULL_PCT = 7'd100;
    localparam logic [6:0] HALF_PCT = 7'd50;

    // sextant boundaries in degrees
    localparam logic [8:0] DEG_60  = 9'd60;
    localparam logic [8:0] DEG_120 = 9'd120;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_240 = 9'd240;
    localparam logic [8:0] DEG_300 = 9'd300;

    // sextant codes
    localparam logic [2:0] SEXT_0 = 3'd0;
    localparam logic [2:0] SEXT_1 = 3'd1;
    localparam logic [2:0] SEXT_2 = 3'd2;
    localparam logic [2:0] SEXT_3 = 3'd3;
    localparam logic [2:0] SEXT_4 = 3'd4;
    localparam logic [2:0] SEXT_5 = 3'd5;

    // scale factors from the 1/100 to the 1/10000 grid and from there to the 1/600000 grid
    localparam logic [13:0] PCT_SCALE  = 14'd100;
    localparam logic [19:0] SEXT_SCALE = 20'd60;

    // 31 * ceil(2^44 / 600000): floor(31 * num / 600000) for num up to 600000
    localparam logic [29:0] CHAN_RECIP  = 30'd908929641;
    localparam int          RECIP_SHIFT = 44;

    // register stages between input and output
    localparam logic [2:0] PIPE_DEPTH = 3'd5;

    // after hue wrap, clamp and sextant split
    typedef struct packed {
        logic [2:0] sext;
        logic [5:0] frac;
        logic [6:0] sat;
        logic [6:0] lum;
    } t_front;

    // v = base + t, m = base - t, over 10000
    typedef struct packed {
        logic [2:0]  sext;
        logic [5:0]  frac;
        logic [13:0] base;
        logic [12:0] t;
    } t_chroma;

    // v, m and the ramp step over 600000
    typedef struct packed {
        logic [2:0]  sext;
        logic [19:0] v60;
        logic [19:0] m60;
        logic [19:0] d;
    } t_span;

    // channel numerators over 600000
    typedef struct packed {
        logic [19:0] r;
        logic [19:0] g;
        logic [19:0] b;
    } t_num;

endpackage

### hdl/hsl2r_if.sv
interface hsl2r_hsl_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue_deg;
    logic [6:0] saturation_pct;
    logic [6:0] lightness_pct;

    modport source (output valid, output hue_deg, output saturation_pct,
                    output lightness_pct, input ready);
    modport sink   (input valid, input hue_deg, input saturation_pct,
                    input lightness_pct, output ready);
endinterface

interface hsl2r_rgb_if;
    logic       valid;
    logic       ready;
    logic [4:0] red_out;
    logic [4:0] green_out;
    logic [4:0] blue_out;

    modport source (output valid, output red_out, output green_out,
                    output blue_out, input ready);
    modport sink   (input valid, input red_out, input green_out,
                    input blue_out, output ready);
endinterface

### hdl/hsl2r_front.sv
module hsl2r_front import hsl2r_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [8:0] i_hue_deg,
    input  logic [6:0] i_saturation_pct,
    input  logic [6:0] i_lightness_pct,
    output logic       o_ready,
    output logic       o_valid,
    output t_chroma    o_data,
    input  logic       i_ready
);

    logic       r_v1;
    t_front     r_d1;
    t_front     n_d1;
    logic       r_v2;
    t_chroma    n_d2;
    t_chroma    r_d2;
    logic       s1_ready;
    logic       s2_ready;
    logic [8:0] hue_w;
    logic [8:0] sext_off;
    logic [6:0] lum_arm;
    logic [13:0] prod;

    // per-stage ready fills bubbles
    assign s2_ready = !r_v2 || i_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign o_ready  = s1_ready;

    // hue wrap, clamp and sextant split
    always_comb begin
        hue_w = (i_hue_deg >= FULL_DEG) ? i_hue_deg - FULL_DEG : i_hue_deg;
        priority if (hue_w >= DEG_300) begin
            n_d1.sext = SEXT_5;
            sext_off  = DEG_300;
        end else if (hue_w >= DEG_240) begin
            n_d1.sext = SEXT_4;
            sext_off  = DEG_240;
        end else if (hue_w >= DEG_180) begin
            n_d1.sext = SEXT_3;
            sext_off  = DEG_180;
        end else if (hue_w >= DEG_120) begin
            n_d1.sext = SEXT_2;
            sext_off  = DEG_120;
        end else if (hue_w >= DEG_60) begin
            n_d1.sext = SEXT_1;
            sext_off  = DEG_60;
        end else begin
            n_d1.sext = SEXT_0;
            sext_off  = 9'd0;
        end
        n_d1.frac = 6'(hue_w - sext_off);
        n_d1.sat  = (i_saturation_pct > FULL_PCT) ? FULL_PCT : i_saturation_pct;
        n_d1.lum  = (i_lightness_pct > FULL_PCT) ? FULL_PCT : i_lightness_pct;
    end

    // chroma term: t = s * min(l, 100 - l)
    always_comb begin
        lum_arm     = (r_d1.lum <= HALF_PCT) ? r_d1.lum : FULL_PCT - r_d1.lum;
        prod        = 14'(r_d1.sat) * 14'(lum_arm);
        n_d2.sext   = r_d1.sext;
        n_d2.frac   = r_d1.frac;
        n_d2.base   = 14'(r_d1.lum) * PCT_SCALE;
        n_d2.t      = prod[12:0];
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_d1 <= n_d1;
        end
        if (s2_ready && r_v1) begin
            r_d2 <= n_d2;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_d2;

endmodule

### hdl/hsl2r_mix.sv
module hsl2r_mix import hsl2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_chroma i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_num    o_data,
    input  logic    i_ready
);

    logic        r_v3;
    t_span       r_d3;
    t_span       n_d3;
    logic        r_v4;
    t_num        r_d4;
    t_num        n_d4;
    logic        s3_ready;
    logic        s4_ready;
    logic [13:0] v_pct;
    logic [13:0] m_pct;
    logic [19:0] mid1;
    logic [19:0] mid2;

    assign s4_ready = !r_v4 || i_ready;
    assign s3_ready = !r_v3 || s4_ready;
    assign o_ready  = s3_ready;

    // v and m on the common grid, ramp step (v - m) * frac / 60
    always_comb begin
        v_pct    = i_data.base + 14'(i_data.t);
        m_pct    = i_data.base - 14'(i_data.t);
        n_d3.sext = i_data.sext;
        n_d3.v60  = 20'(v_pct) * SEXT_SCALE;
        n_d3.m60  = 20'(m_pct) * SEXT_SCALE;
        n_d3.d    = 20'({i_data.t, 1'b0}) * 20'(i_data.frac);
    end

    // rising and falling ramps, channel routing by sextant
    always_comb begin
        mid1 = r_d3.m60 + r_d3.d;
        mid2 = r_d3.v60 - r_d3.d;
        unique case (r_d3.sext)
            SEXT_0: begin
                n_d4.r = r_d3.v60; n_d4.g = mid1;      n_d4.b = r_d3.m60;
            end
            SEXT_1: begin
                n_d4.r = mid2;     n_d4.g = r_d3.v60;  n_d4.b = r_d3.m60;
            end
            SEXT_2: begin
                n_d4.r = r_d3.m60; n_d4.g = r_d3.v60;  n_d4.b = mid1;
            end
            SEXT_3: begin
                n_d4.r = r_d3.m60; n_d4.g = mid2;      n_d4.b = r_d3.v60;
            end
            SEXT_4: begin
                n_d4.r = mid1;     n_d4.g = r_d3.m60;  n_d4.b = r_d3.v60;
            end
            default: begin
                n_d4.r = r_d3.v60; n_d4.g = r_d3.m60;  n_d4.b = mid2;
            end
        endcase
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s3_ready) begin
                r_v3 <= i_valid;
            end
            if (s4_ready) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && i_valid) begin
            r_d3 <= n_d3;
        end
        if (s4_ready && r_v3) begin
            r_d4 <= n_d4;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_d4;

endmodule

### hdl/hsl2r_scale.sv
module hsl2r_scale import hsl2r_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_num       i_data,
    output logic       o_ready,
    output logic       o_valid,
    output logic [4:0] o_red_out,
    output logic [4:0] o_green_out,
    output logic [4:0] o_blue_out,
    input  logic       i_ready
);

    logic        r_v5;
    logic [4:0]  r_red;
    logic [4:0]  r_green;
    logic [4:0]  r_blue;
    logic        s5_ready;
    logic [49:0] prod_r;
    logic [49:0] prod_g;
    logic [49:0] prod_b;

    assign s5_ready = !r_v5 || i_ready;
    assign o_ready  = s5_ready;

    // floor(31 * num / 600000) by reciprocal multiply, exact over the range
    always_comb begin
        prod_r = 50'(i_data.r) * 50'(CHAN_RECIP);
        prod_g = 50'(i_data.g) * 50'(CHAN_RECIP);
        prod_b = 50'(i_data.b) * 50'(CHAN_RECIP);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (s5_ready) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_ready && i_valid) begin
            r_red   <= prod_r[RECIP_SHIFT +: 5];
            r_green <= prod_g[RECIP_SHIFT +: 5];
            r_blue  <= prod_b[RECIP_SHIFT +: 5];
        end
    end

    assign o_valid     = r_v5;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

endmodule

### hdl/hsl_to_rgb555_top.sv
// pipeline: from input transfer to result, through front, mix and scale,
//   one register per stage
// throughput: one color per cycle, every stage takes a new item each cycle;
//   a stall holds the full stages up to the output, bubbles are filled
// reset: i_rst_n synchronous active low clears all stage valid bits,
//   the data registers are not reset
module hsl_to_rgb555_top import hsl2r_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsl2r_hsl_if.sink   i_hsl,
    hsl2r_rgb_if.source o_rgb
);

    logic    front_valid;
    t_chroma front_data;
    logic    mix_ready;
    logic    mix_valid;
    t_num    mix_data;
    logic    scale_ready;

    // clamp, sextant split and chroma product
    hsl2r_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_hsl.valid),
        .i_hue_deg        (i_hsl.hue_deg),
        .i_saturation_pct (i_hsl.saturation_pct),
        .i_lightness_pct  (i_hsl.lightness_pct),
        .o_ready          (i_hsl.ready),
        .o_valid          (front_valid),
        .o_data           (front_data),
        .i_ready          (mix_ready)
    );

    // v, m, ramps and channel routing
    hsl2r_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_ready (mix_ready),
        .o_valid (mix_valid),
        .o_data  (mix_data),
        .i_ready (scale_ready)
    );

    // scale to five bits, output register
    hsl2r_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (mix_valid),
        .i_data      (mix_data),
        .o_ready     (scale_ready),
        .o_valid     (o_rgb.valid),
        .o_red_out   (o_rgb.red_out),
        .o_green_out (o_rgb.green_out),
        .o_blue_out  (o_rgb.blue_out),
        .i_ready     (o_rgb.ready)
    );

endmodule

### hdl/hsl2r_chk.sv
module hsl2r_chk import hsl2r_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [14:0] i_out_data
);

    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       in_xfer;
    logic       out_xfer;

    // items inside the pipeline
    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_xfer && !out_xfer) begin
            n_cnt = r_cnt + 3'd1;
        end else if (out_xfer && !in_xfer) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // never more items in flight than stages
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= PIPE_DEPTH)
        else $error("more items in flight than pipeline stages");

    // no result without an earlier input transfer
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 3'd0)
        else $error("result shown with empty pipeline");

    // a free stage anywhere lets the input in
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < PIPE_DEPTH |-> i_in_ready)
        else $error("input held off while a stage is free");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result dropped or changed");

endmodule

bind hsl_to_rgb555_top hsl2r_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_hsl.valid),
    .i_in_ready  (i_hsl.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_out_data  ({o_rgb.red_out, o_rgb.green_out, o_rgb.blue_out})
);

### verif/testbench.sv
module testbench;
    import hsl2r_pkg::*;

    // one color on the input side
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lum;
    } t_hsl;

    // one 555 color on the output side
    typedef struct packed {
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
    } t_rgb;

    // predicted color together with the input that caused it
    typedef struct packed {
        t_hsl src;
        t_rgb rgb;
    } t_rgb_due;

    localparam int HOLD_CYCLES  = 64;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    logic i_clk;
    logic i_rst_n;

    hsl2r_hsl_if hsl_bus ();
    hsl2r_rgb_if rgb_bus ();

    hsl_to_rgb555_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hsl   (hsl_bus),
        .o_rgb   (rgb_bus)
    );

    t_hsl     hsl_queue[$];
    t_rgb_due rgb_pending[$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;
    logic hsl_taken     = 1'b0;
    int   quiet_cycles  = 0;

    int n_colors_in   = 0;
    int n_colors_out  = 0;
    int n_fail        = 0;
    int n_input_stall = 0;
    int n_wrapped     = 0;

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // floor(31 * num / 600000), kept to five bits
    function automatic logic [4:0] chan_of(int unsigned num);
        longint unsigned scaled;
        scaled = longint'(num) * 31 / 600000;
        return scaled[4:0];
    endfunction

    // six-sextant hsl to rgb on the 1/600000 grid
    function automatic t_rgb rgb_from_hsl(t_hsl c);
        int unsigned hue, sat, lum, v, m, d, mid1, mid2, frac, r, g, b;
        logic [2:0]  sext;
        t_rgb        res;
        hue = c.hue;
        sat = c.sat;
        lum = c.lum;
        if (hue >= FULL_DEG) hue -= FULL_DEG;
        if (sat > FULL_PCT) sat = FULL_PCT;
        if (lum > FULL_PCT) lum = FULL_PCT;
        // v and m over 10000
        if (lum * 2 <= FULL_PCT)
            v = lum * (FULL_PCT + sat);
        else
            v = FULL_PCT * lum + FULL_PCT * sat - lum * sat;
        m = 2 * FULL_PCT * lum - v;
        v *= 60;
        m *= 60;
        if (v == 0) begin
            r = lum * 6000;
            g = r;
            b = r;
        end else begin
            sext = 3'(hue / 60);
            frac = hue % 60;
            d    = ((v - m) / 60) * frac;
            mid1 = m + d;
            mid2 = v - d;
            case (sext)
                SEXT_0: begin r = v;    g = mid1; b = m;    end
                SEXT_1: begin r = mid2; g = v;    b = m;    end
                SEXT_2: begin r = m;    g = v;    b = mid1; end
                SEXT_3: begin r = m;    g = mid2; b = v;    end
                SEXT_4: begin r = mid1; g = m;    b = v;    end
                default: begin r = v;   g = m;    b = mid2; end
            endcase
        end
        res.r = chan_of(r);
        res.g = chan_of(g);
        res.b = chan_of(b);
        return res;
    endfunction

    task automatic push_hsl(int unsigned h, int unsigned s, int unsigned l);
        t_hsl c;
        c.hue = h[8:0];
        c.sat = s[6:0];
        c.lum = l[6:0];
        if (c.hue >= FULL_DEG || c.sat > FULL_PCT || c.lum > FULL_PCT) n_wrapped++;
        hsl_queue.push_back(c);
    endtask

    // mostly legal colors, some over the full field range
    task automatic push_random(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0)
                push_hsl($urandom_range(0, 511), $urandom_range(0, 127),
                         $urandom_range(0, 127));
            else
                push_hsl($urandom_range(0, 360), $urandom_range(0, 100),
                         $urandom_range(0, 100));
        end
    endtask

    // input driver, changes on the falling edge
    always @(negedge i_clk) begin
        t_hsl c;
        if (i_rst_n && (!hsl_bus.valid || hsl_taken)) begin
            if (hsl_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                c = hsl_queue.pop_front();
                hsl_bus.valid          <= 1'b1;
                hsl_bus.hue_deg        <= c.hue;
                hsl_bus.saturation_pct <= c.sat;
                hsl_bus.lightness_pct  <= c.lum;
            end else begin
                hsl_bus.valid <= 1'b0;
            end
        end
    end

    // output ready, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            rgb_bus.ready <= 1'b0;
        end else begin
            rgb_bus.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // input transfer prediction and output transfer check
    always @(posedge i_clk) begin
        t_rgb_due due;
        t_hsl     c;
        t_rgb     got;
        if (!i_rst_n) begin
            hsl_taken <= 1'b0;
        end else begin
            hsl_taken <= hsl_bus.valid && hsl_bus.ready;
            if (hsl_bus.valid && hsl_bus.ready) begin
                c.hue   = hsl_bus.hue_deg;
                c.sat   = hsl_bus.saturation_pct;
                c.lum   = hsl_bus.lightness_pct;
                due.src = c;
                due.rgb = rgb_from_hsl(c);
                rgb_pending.push_back(due);
                n_colors_in++;
            end
            if (hsl_bus.valid && !hsl_bus.ready) n_input_stall++;
            if (rgb_bus.valid && rgb_bus.ready) begin
                got.r = rgb_bus.red_out;
                got.g = rgb_bus.green_out;
                got.b = rgb_bus.blue_out;
                n_colors_out++;
                if (rgb_pending.size() == 0) begin
                    n_fail++;
                    if (n_fail <= REPORT_MAX)
                        $display("unexpected color %0d,%0d,%0d with nothing pending",
                                 got.r, got.g, got.b);
                end else begin
                    due = rgb_pending.pop_front();
                    if (got !== due.rgb) begin
                        n_fail++;
                        if (n_fail <= REPORT_MAX)
                            $display("hsl %0d/%0d/%0d: expected rgb %0d,%0d,%0d got %0d,%0d,%0d",
                                     due.src.hue, due.src.sat, due.src.lum,
                                     due.rgb.r, due.rgb.g, due.rgb.b,
                                     got.r, got.g, got.b);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((hsl_bus.valid && hsl_bus.ready) || (rgb_bus.valid && rgb_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d colors pending",
                         quiet_cycles, rgb_pending.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // reset, stimulus phases and end of run
    initial begin
        i_rst_n                = 1'b0;
        hsl_bus.valid          = 1'b0;
        hsl_bus.hue_deg        = '0;
        hsl_bus.saturation_pct = '0;
        hsl_bus.lightness_pct  = '0;
        rgb_bus.ready          = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender idles less than receiver; corners first
        send_idle_pct = 31;
        recv_idle_pct = 81;
        push_hsl(0, 100, 50);
        push_hsl(60, 100, 50);
        push_hsl(120, 100, 50);
        push_hsl(180, 100, 50);
        push_hsl(240, 100, 50);
        push_hsl(300, 100, 50);
        push_hsl(359, 100, 50);
        push_hsl(360, 100, 50);
        push_hsl(511, 100, 50);
        push_hsl(30, 100, 25);
        push_hsl(90, 60, 75);
        push_hsl(150, 40, 51);
        push_hsl(210, 100, 100);
        push_hsl(270, 127, 127);
        push_hsl(330, 0, 70);
        push_hsl(45, 80, 0);
        push_hsl(0, 0, 0);
        push_hsl(511, 127, 0);
        push_hsl(100, 100, 1);
        push_hsl(200, 1, 99);
        push_hsl(359, 99, 49);
        push_hsl(15, 127, 50);
        push_hsl(400, 50, 127);
        push_random(340);
        while (hsl_queue.size() != 0) @(posedge i_clk);

        // receiver idles less than sender
        send_idle_pct = 81;
        recv_idle_pct = 31;
        push_random(340);
        while (hsl_queue.size() != 0) @(posedge i_clk);

        // full rate, with one long output hold-off to back the pipe up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(350);
        @(posedge i_clk);
        hold_req = 1'b1;
        while (hsl_queue.size() != 0) @(posedge i_clk);

        while (rgb_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d colors in, %0d out, %0d with hue wrap or percent clamp",
                 n_colors_in, n_colors_out, n_wrapped);
        $display("%0d input stall cycles, %0d failures", n_input_stall, n_fail);
        if (n_fail == 0 && rgb_pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hdl/hsl2r_pkg.sv
hdl/hsl2r_if.sv
hdl/hsl2r_front.sv
hdl/hsl2r_mix.sv
hdl/hsl2r_scale.sv
hdl/hsl_to_rgb555_top.sv
hdl/hsl2r_chk.sv
verif/testbench.sv
